FILE: hw/rtl/pjd_pkg.sv
// Shared types and constants of the priority job dispatcher.
package pjd_pkg;

    localparam int unsigned ResMax = 16;

    typedef enum logic [0:0] {
        FUNC_SUBMIT = 1'b0,
        FUNC_ASSIGN = 1'b1
    } func_t;

    typedef enum logic [0:0] {
        STATUS_DISPATCHED = 1'b0,
        STATUS_REJECTED   = 1'b1
    } status_t;

    typedef struct packed {
        logic [0:0]  func;
        logic [31:0] time_now;
        logic [31:0] process_id;
        logic [7:0]  origin_id;
        logic [7:0]  instr_id;
        logic [15:0] importance;
        logic [31:0] run_length;
        logic [4:0]  max_assign;
    } in_item_t;

    typedef struct packed {
        logic [0:0]  status;
        logic [31:0] job_time;
        logic [31:0] job_process;
        logic [7:0]  job_origin;
        logic [7:0]  job_instr;
        logic [15:0] job_importance;
        logic [31:0] job_length;
        logic [0:0]  last;
    } out_item_t;

    // Stored job: time, process, origin, instr, importance, length.
    typedef struct packed {
        logic [31:0] t;
        logic [31:0] proc_id;
        logic [7:0]  org;
        logic [7:0]  ins;
        logic [15:0] imp;
        logic [31:0] len;
    } entry_t;

    localparam int unsigned EntryW = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FREE,
        ST_SLOT_SCAN,
        ST_SLOT_WAIT,
        ST_WRITE,
        ST_REJECT,
        ST_CPU_PICK,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_READ,
        ST_READ_WAIT,
        ST_EMIT,
        ST_OUT_WAIT
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_item;
        logic release_cpus;
        logic slot_clear;
        logic slot_step;
        logic write_job;
        logic scan_clear;
        logic scan_step;
        logic read_best;
        logic take_best;
        logic emit_job;
        logic emit_reject;
        logic emit_last;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_assign;
        logic scan_done;
        logic slot_found;
        logic best_found;
        logic cpu_found;
        logic count_done;
        logic out_busy;
    } sts_t;

endpackage

FILE: hw/rtl/priority_job_dispatcher.sv
// Top level of the priority job dispatcher.
// A submit item scans the job table for the first free slot and writes the job there;
// a full table gives one rejected result. An assign item first frees finished CPUs,
// then chooses each dispatched job by a scan of the job table through its single read
// port. The last result of an item carries last set. cpu_count is to be written through
// the cfg port only while the block is idle; the block itself does not enforce this.
module priority_job_dispatcher #(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned MAX_CPUS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pjd_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pjd_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data
);

    pjd_pkg::cmd_t cmd;
    pjd_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    pjd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pjd_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_CPUS(MAX_CPUS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_data)
    );

endmodule

FILE: hw/rtl/pjd_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module pjd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/pjd_ctrl.sv
// Controller state machine of the priority job dispatcher.
module pjd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pjd_pkg::sts_t  sts,
    output pjd_pkg::cmd_t  cmd
);

    pjd_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pjd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pjd_pkg::ST_IDLE:
                if (in_valid) state_next = pjd_pkg::ST_FREE;
            pjd_pkg::ST_FREE:
                state_next = sts.is_assign ? pjd_pkg::ST_CPU_PICK : pjd_pkg::ST_SLOT_SCAN;
            pjd_pkg::ST_SLOT_SCAN:
                if (sts.slot_found) state_next = pjd_pkg::ST_SLOT_WAIT;
                else if (sts.scan_done) state_next = pjd_pkg::ST_REJECT;
            pjd_pkg::ST_SLOT_WAIT:
                state_next = pjd_pkg::ST_WRITE;
            pjd_pkg::ST_WRITE:
                state_next = pjd_pkg::ST_IDLE;
            pjd_pkg::ST_REJECT:
                if (!sts.out_busy) state_next = pjd_pkg::ST_IDLE;
            pjd_pkg::ST_CPU_PICK:
                if (sts.count_done || !sts.cpu_found) state_next = pjd_pkg::ST_OUT_WAIT;
                else state_next = pjd_pkg::ST_SCAN;
            pjd_pkg::ST_SCAN:
                if (sts.scan_done) state_next = pjd_pkg::ST_SCAN_WAIT;
            pjd_pkg::ST_SCAN_WAIT:
                state_next = sts.best_found ? pjd_pkg::ST_READ : pjd_pkg::ST_OUT_WAIT;
            pjd_pkg::ST_READ:
                state_next = pjd_pkg::ST_READ_WAIT;
            pjd_pkg::ST_READ_WAIT:
                state_next = pjd_pkg::ST_EMIT;
            pjd_pkg::ST_EMIT:
                if (!sts.out_busy) state_next = pjd_pkg::ST_CPU_PICK;
            pjd_pkg::ST_OUT_WAIT:
                if (!sts.out_busy) state_next = pjd_pkg::ST_IDLE;
            default:
                state_next = pjd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            pjd_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            pjd_pkg::ST_FREE:
            begin
                // Only an assign item releases finished CPUs.
                cmd.release_cpus = sts.is_assign;
                cmd.slot_clear   = 1'b1;
            end
            pjd_pkg::ST_SLOT_SCAN:
                cmd.slot_step = !sts.slot_found;
            pjd_pkg::ST_WRITE:
                cmd.write_job = 1'b1;
            pjd_pkg::ST_REJECT:
                cmd.emit_reject = !sts.out_busy;
            pjd_pkg::ST_CPU_PICK:
                cmd.scan_clear = 1'b1;
            pjd_pkg::ST_SCAN:
                cmd.scan_step = 1'b1;
            pjd_pkg::ST_READ:
                cmd.read_best = 1'b1;
            pjd_pkg::ST_EMIT:
            begin
                cmd.emit_job  = !sts.out_busy;
                cmd.take_best = !sts.out_busy;
            end
            pjd_pkg::ST_OUT_WAIT:
                cmd.emit_last = !sts.out_busy;
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/pjd_datapath.sv
// Datapath: job table, CPU timers, best-job scan and output holding.
module pjd_datapath #(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned MAX_CPUS    = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pjd_pkg::in_item_t   in_item,
    input  logic                cfg_valid,
    input  logic [4:0]          cfg_data,
    input  pjd_pkg::cmd_t       cmd,
    output pjd_pkg::sts_t       sts,
    output logic                out_valid,
    input  logic                out_ready,
    output pjd_pkg::out_item_t  out_item
);

    localparam int unsigned QW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int unsigned OW = $bits(pjd_pkg::out_item_t);

    pjd_pkg::in_item_t item_reg;
    logic [4:0]        cpu_count_reg;
    logic [QUEUE_DEPTH-1:0] wait_valid_reg;
    logic [MAX_CPUS-1:0]    cpu_busy_reg;
    logic [32:0]            done_reg [MAX_CPUS];

    logic [QW:0]   scan_reg;
    logic [QW-1:0] rd_addr_d;
    logic          rd_valid_reg;
    logic [QW-1:0] rd_idx_reg;
    logic [QW-1:0] best_idx_reg;
    logic          best_found_reg;
    pjd_pkg::entry_t best_reg;
    logic [4:0]    n_reg;
    logic [CW-1:0] cpu_idx;
    logic          cpu_found;
    logic [4:0]    k_sat;
    logic [6:0]    ncpu;
    pjd_pkg::entry_t rd_entry, wr_entry;
    logic [pjd_pkg::EntryW-1:0] rd_raw;
    logic          pend_reg;
    pjd_pkg::out_item_t pend_item_reg;
    logic          better;

    assign rd_entry = pjd_pkg::entry_t'(rd_raw);
    assign wr_entry = '{t: item_reg.time_now, proc_id: item_reg.process_id,
                        org: item_reg.origin_id, ins: item_reg.instr_id,
                        imp: item_reg.importance, len: item_reg.run_length};
    assign rd_addr_d = cmd.read_best ? best_idx_reg : scan_reg[QW-1:0];

    pjd_ram #(.WIDTH(pjd_pkg::EntryW), .DEPTH(QUEUE_DEPTH)) u_table (
        .clk     (clk),
        .wr_en   (cmd.write_job),
        .wr_addr (best_idx_reg),
        .wr_data (wr_entry),
        .rd_addr (rd_addr_d),
        .rd_data (rd_raw)
    );

    always_comb
    begin
        k_sat = (item_reg.max_assign > 5'(pjd_pkg::ResMax)) ?
                5'(pjd_pkg::ResMax) : item_reg.max_assign;
        ncpu  = (7'(cpu_count_reg) > 7'(MAX_CPUS)) ? 7'(MAX_CPUS) : 7'(cpu_count_reg);
        cpu_idx   = '0;
        cpu_found = 1'b0;
        for (int i = MAX_CPUS - 1; i >= 0; i--)
        begin
            if (7'(i) < ncpu && !cpu_busy_reg[i])
            begin
                cpu_idx   = CW'(i);
                cpu_found = 1'b1;
            end
        end
        if (rd_entry.imp != best_reg.imp) better = rd_entry.imp > best_reg.imp;
        else if (rd_entry.t != best_reg.t) better = rd_entry.t < best_reg.t;
        else better = rd_entry.len < best_reg.len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_count_reg  <= 5'd1;
            wait_valid_reg <= '0;
            cpu_busy_reg   <= '0;
            scan_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            n_reg          <= '0;
            pend_reg       <= 1'b0;
            out_valid      <= 1'b0;
        end
        else
        begin
            if (cfg_valid) cpu_count_reg <= cfg_data;
            if (cmd.load_item) n_reg <= '0;
            if (cmd.release_cpus)
            begin
                for (int i = 0; i < MAX_CPUS; i++)
                begin
                    if (cpu_busy_reg[i] && done_reg[i] <= {1'b0, item_reg.time_now})
                        cpu_busy_reg[i] <= 1'b0;
                end
            end
            if (cmd.slot_clear || cmd.scan_clear)
            begin
                scan_reg       <= '0;
                best_found_reg <= 1'b0;
            end
            if (cmd.slot_step)
            begin
                if (!wait_valid_reg[scan_reg[QW-1:0]])
                begin
                    best_found_reg <= 1'b1;
                    best_idx_reg   <= scan_reg[QW-1:0];
                end
                else
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            if (cmd.write_job) wait_valid_reg[best_idx_reg] <= 1'b1;
            rd_valid_reg <= cmd.scan_step && scan_reg != (QW+1)'(QUEUE_DEPTH) &&
                            wait_valid_reg[scan_reg[QW-1:0]];
            if (cmd.scan_step && scan_reg != (QW+1)'(QUEUE_DEPTH))
            begin
                scan_reg   <= scan_reg + 1'b1;
                rd_idx_reg <= scan_reg[QW-1:0];
            end
            // Compare the entry read last cycle against the current best.
            if (rd_valid_reg && (!best_found_reg || better))
            begin
                best_found_reg <= 1'b1;
                best_idx_reg   <= rd_idx_reg;
                best_reg       <= rd_entry;
            end
            if (cmd.take_best)
            begin
                wait_valid_reg[best_idx_reg] <= 1'b0;
                cpu_busy_reg[cpu_idx]        <= 1'b1;
                done_reg[cpu_idx] <= {1'b0, item_reg.time_now} + {1'b0, best_reg.len};
                n_reg <= n_reg + 1'b1;
            end
            // A dispatched job waits in a pending register so the last one can be marked.
            if (cmd.emit_job)
            begin
                pend_reg <= 1'b1;
                pend_item_reg <= '{status: pjd_pkg::STATUS_DISPATCHED, job_time: best_reg.t,
                                   job_process: best_reg.proc_id, job_origin: best_reg.org,
                                   job_instr: best_reg.ins, job_importance: best_reg.imp,
                                   job_length: best_reg.len, last: 1'b0};
            end
            else if (cmd.emit_last)
            begin
                pend_reg <= 1'b0;
            end
            if (cmd.emit_reject)
            begin
                out_item  <= pjd_pkg::out_item_t'({pjd_pkg::STATUS_REJECTED,
                                                    {(OW-2){1'b0}}, 1'b1});
                out_valid <= 1'b1;
            end
            else if (cmd.emit_last && pend_reg)
            begin
                out_item  <= pjd_pkg::out_item_t'({pend_item_reg[OW-1:1], 1'b1});
                out_valid <= 1'b1;
            end
            else if (cmd.emit_job && pend_reg)
            begin
                out_item  <= pend_item_reg;
                out_valid <= 1'b1;
            end
            else if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item) item_reg <= in_item;
    end

    always_comb
    begin
        sts.is_assign  = item_reg.func == pjd_pkg::FUNC_ASSIGN;
        sts.scan_done  = scan_reg == (QW+1)'(QUEUE_DEPTH);
        sts.slot_found = best_found_reg;
        sts.best_found = best_found_reg || rd_valid_reg;
        sts.cpu_found  = cpu_found;
        sts.count_done = n_reg >= k_sat;
        sts.out_busy   = out_valid && !out_ready;
    end

endmodule
